// File: design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types for the sorted score table
// Item layouts, the stored record, and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int RANK_W  = 5;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;

  // kind codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [31:0]        new_id;
    logic signed [31:0] new_score;
    logic [7:0]         new_tag;
    logic [RANK_W-1:0]  read_rank;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [POS_W-1:0]   insert_position;
    logic [COUNT_W-1:0] entry_count;
    logic               rank_valid;
    logic [31:0]        rank_id;
    logic signed [31:0] rank_score;
    logic [7:0]         rank_tag;
    logic [31:0]        best_id;
    logic signed [31:0] best_score;
    logic [31:0]        worst_id;
    logic signed [31:0] worst_score;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [31:0] score;
    logic [7:0]         tag;
  } record_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the request, index starts at the count
    logic rd_prev;  // read the record just above the index
    logic rd_rank;  // read the record at the requested rank
    logic shift;    // move the read record down one place, index steps up
    logic place;    // store the new record at the index
    logic capture;  // latch the read record as the rank result
    logic emit;     // load the result register
  } sst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_insert;
    logic full;
    logic idx_zero;
    logic prev_le;   // record read above the index scores <= new score
    logic rank_ok;
    logic out_free;
  } sst_stat_t;

endpackage

// File: design/sorted_score_table_insert.sv
// ----------------------------------------------------------------------------
// sorted_score_table_insert: ranked table of (id, score, tag) records
// Keeps up to DEPTH records in descending signed Q16.16 score order; inserts
// go ahead of equal scores, reads return the record at a rank.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one item: an insert
//   (kind 0) or a rank read (kind 1). rsp channel (rsp_valid / rsp_stall /
//   rsp) returns exactly one result item per request item, in order.
//   The table takes one item at a time; req_stall is high from the cycle
//   after an item is accepted until its result has gone to the output
//   register.
//   Sequence from acceptance to the result:
//     read            : a registered read at the rank (skipped when the
//                       rank is past the count), then the result
//     insert          : records scoring <= the new score move down one
//                       place from the tail upwards, then the new record is
//                       placed (rejected without a scan when full)
//   The next item is taken the cycle after the result is loaded.
//   The cost of an insert is set by the record scan: each record moved
//   takes one read and one write, from the tail upwards.
//   Result register: a finished result waits there while rsp_stall is high;
//   the block may accept the next item meanwhile, and holds that item's
//   result back until the register frees.
//   Reset (rst, synchronous): empties the table (count 0) and drops any
//   pending result. Record storage is not cleared; only ranks below the
//   count are ever read.
// ----------------------------------------------------------------------------
module sorted_score_table_insert
  import sst_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  sst_cmd_t  cmd;
  sst_stat_t stat;

  // sequencer: insert scan / rank read / result hand-off
  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // record memory, count, best/worst and the result register
  sst_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: design/sst_datapath.sv
// ----------------------------------------------------------------------------
// sst_datapath: record memory, scan index, count and result register
// Moves records down one place per shift command, holds best/worst records
// and builds the result item.
// ----------------------------------------------------------------------------
module sst_datapath
  import sst_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  req,
  input  sst_cmd_t  cmd,
  output sst_stat_t stat,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = CW + RANK_W;

  record_t          mem [DEPTH];
  record_t          rd_rec;
  in_item_t         item;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    count;
  logic             res_accepted;
  logic [POS_W-1:0] res_pos;
  logic             res_rank_valid;
  record_t          res_rank;
  record_t          best;
  record_t          worst;
  record_t          new_rec;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             empty;

  assign new_rec = '{id: item.new_id, score: item.new_score, tag: item.new_tag};
  assign wr_addr = AW'(idx);
  assign rd_addr = cmd.rd_prev ? AW'(idx - CW'(1)) : AW'(item.read_rank);
  assign empty   = (count == '0);

  assign stat.is_insert = (item.kind == KIND_INSERT);
  assign stat.full      = (count == CW'(DEPTH));
  assign stat.idx_zero  = (idx == '0);
  assign stat.prev_le   = (rd_rec.score <= item.new_score);
  assign stat.rank_ok   = (CMPW'(item.read_rank) < CMPW'(count));
  assign stat.out_free  = !rsp_valid || !rsp_stall;

  // record memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mem[wr_addr] <= rd_rec;
    end else if (cmd.place) begin
      mem[wr_addr] <= new_rec;
    end
    if (cmd.rd_prev || cmd.rd_rank) begin
      rd_rec <= mem[rd_addr];
    end
  end

  // control state: count, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.place) begin
        count <= count + CW'(1);
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item           <= req;
      idx            <= count;
      res_accepted   <= 1'b0;
      res_pos        <= '0;
      res_rank_valid <= 1'b0;
      res_rank       <= '0;
    end
    if (cmd.shift) begin
      idx <= idx - CW'(1);
    end
    if (cmd.place) begin
      res_accepted <= 1'b1;
      res_pos      <= POS_W'(idx);
      if (idx == '0) begin
        best <= new_rec;
      end
      if (idx == count) begin
        worst <= new_rec;  // appended at the tail
      end
    end
    if (cmd.capture) begin
      res_rank_valid <= 1'b1;
      res_rank       <= rd_rec;
    end
    if (cmd.emit) begin
      rsp.accepted        <= res_accepted;
      rsp.insert_position <= res_pos;
      rsp.entry_count     <= COUNT_W'(count);
      rsp.rank_valid      <= res_rank_valid;
      rsp.rank_id         <= res_rank.id;
      rsp.rank_score      <= res_rank.score;
      rsp.rank_tag        <= res_rank.tag;
      rsp.best_id         <= empty ? '0 : best.id;
      rsp.best_score      <= empty ? '0 : best.score;
      rsp.worst_id        <= empty ? '0 : worst.id;
      rsp.worst_score     <= empty ? '0 : worst.score;
    end
  end

endmodule

// File: design/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl: sequencing for the sorted score table
// Steps an insert up from the tail one record at a time, or issues a rank
// read, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sst_ctrl
  import sst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  sst_stat_t stat,
  output sst_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_RANK   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.is_insert) begin
          if (stat.rank_ok) begin
            cmd.rd_rank = 1'b1;
            state_next  = ST_RANK;
          end else begin
            state_next = ST_FINISH;
          end
        end else if (stat.full) begin
          state_next = ST_FINISH;
        end else if (stat.idx_zero) begin
          cmd.place  = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.prev_le) begin
          cmd.shift  = 1'b1;
          state_next = ST_DECIDE;
        end else begin
          cmd.place  = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_RANK: begin
        cmd.capture = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker: port-level checks for the sorted score table
// Watches the result channel for holding under stall and for consistency of
// the reported table state.
// ----------------------------------------------------------------------------
module sst_checker
  import sst_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input logic      clk,
  input logic      rst,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input out_item_t rsp
);

  // held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // nothing pending straight after reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // an item is either an insert or a read, never both
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.accepted && rsp.rank_valid))
    else $error("insert and read flags both set");

  // placed rank lies inside the table
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted |->
      (rsp.insert_position < rsp.entry_count) || (DEPTH > 32))
    else $error("insert position beyond count");

  // table stays ordered: best never below worst; empty reports zeros
  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.best_score >= rsp.worst_score) &&
      ((rsp.entry_count != '0) ||
       (rsp.best_id == '0 && rsp.worst_id == '0)))
    else $error("best/worst inconsistent");

endmodule

bind sorted_score_table_insert sst_checker #(.DEPTH(DEPTH)) u_sst_checker (.*);
